@@ rtl/core/tpc_pkg.sv @@
package tpc_pkg;

  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_ONE,
    KIND_TWO,
    KIND_THREE,
    KIND_DROP
  } kind_t;

  localparam int RATIO_BITS = 32;
  localparam int BITS_PER_CYCLE = 4;
  localparam int DIV_STEPS = RATIO_BITS / BITS_PER_CYCLE;

  localparam logic [2:0] REG_PLANE_X  = 3'd0;
  localparam logic [2:0] REG_PLANE_Y  = 3'd1;
  localparam logic [2:0] REG_PLANE_Z  = 3'd2;
  localparam logic [2:0] REG_NORMAL_X = 3'd3;
  localparam logic [2:0] REG_NORMAL_Y = 3'd4;
  localparam logic [2:0] REG_NORMAL_Z = 3'd5;

  localparam kind_t CASE_KIND [16] = '{
    KIND_PASS, KIND_ONE, KIND_ONE, KIND_TWO,
    KIND_ONE, KIND_TWO, KIND_TWO, KIND_THREE,
    KIND_ONE, KIND_TWO, KIND_TWO, KIND_THREE,
    KIND_TWO, KIND_THREE, KIND_THREE, KIND_DROP
  };

  localparam logic [1:0] CASE_PERM [16][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd0, 2'd3}, '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd1, 2'd2, 2'd0, 2'd3}, '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd3, 2'd0, 2'd2, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2},
    '{2'd1, 2'd3, 2'd2, 2'd0}, '{2'd0, 2'd3, 2'd1, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd1, 2'd3, 2'd2, 2'd0}, '{2'd0, 2'd1, 2'd2, 2'd3}
  };

  localparam logic [1:0] EDGE_FROM [5][4] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd0, 2'd0, 2'd1, 2'd1},
    '{2'd3, 2'd3, 2'd3, 2'd0},
    '{2'd0, 2'd0, 2'd0, 2'd0}
  };

  localparam logic [1:0] EDGE_TO [5][4] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd2, 2'd3, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd0},
    '{2'd0, 2'd0, 2'd0, 2'd0}
  };

  localparam logic [1:0] TET_COUNT [5] = '{2'd1, 2'd3, 2'd3, 2'd1, 2'd0};

  localparam logic [2:0] TET_LIST [5][3][4] = '{
    '{'{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0}},
    '{'{3'd1, 3'd2, 3'd5, 3'd3}, '{3'd1, 3'd5, 3'd4, 3'd3}, '{3'd4, 3'd6, 3'd3, 3'd5}},
    '{'{3'd2, 3'd4, 3'd6, 3'd5}, '{3'd2, 3'd3, 3'd5, 3'd6}, '{3'd3, 3'd7, 3'd5, 3'd6}},
    '{'{3'd4, 3'd5, 3'd6, 3'd3}, '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0}},
    '{'{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0}}
  };

endpackage

@@ rtl/core/tpc_if.sv @@
interface tpc_in_if #(parameter int COORD_BITS = 32);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] v0_x, v0_y, v0_z;
  logic signed [COORD_BITS-1:0] v1_x, v1_y, v1_z;
  logic signed [COORD_BITS-1:0] v2_x, v2_y, v2_z;
  logic signed [COORD_BITS-1:0] v3_x, v3_y, v3_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, input ready);
  modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, output ready);
endinterface

interface tpc_out_if #(parameter int COORD_BITS = 32);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] out_x, out_y, out_z;
  logic [1:0] corner;
  logic last;

  modport source (output valid, out_x, out_y, out_z, corner, last, input ready);
  modport sink (input valid, out_x, out_y, out_z, corner, last, output ready);
endinterface

@@ rtl/core/tpc_dist_lane.sv @@
module tpc_dist_lane #(
  parameter int COORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [2:0][COORD_BITS-1:0]  vert,
  input  logic [2:0][COORD_BITS-1:0]  plane,
  input  logic [2:0][COORD_BITS-1:0]  normal,
  output logic signed [2*COORD_BITS+2:0] sdist
);

  localparam int DW = 2 * COORD_BITS + 3;

  logic signed [COORD_BITS:0]   dif [3];
  logic signed [COORD_BITS-1:0] nrm [3];
  logic signed [2*COORD_BITS:0] prod [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dif[j] = $signed({vert[j][COORD_BITS-1], vert[j]})
             - $signed({plane[j][COORD_BITS-1], plane[j]});
      nrm[j] = $signed(normal[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        prod[j] <= dif[j] * nrm[j];
      end
    end
  end

  assign sdist = DW'(prod[0]) + DW'(prod[1]) + DW'(prod[2]);

endmodule

@@ rtl/core/tpc_cut_lane.sv @@
module tpc_cut_lane #(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          start,
  input  logic                          step,
  input  logic signed [2*COORD_BITS+2:0] sa,
  input  logic signed [2*COORD_BITS+2:0] sb,
  input  logic [2:0][COORD_BITS-1:0]    pa,
  input  logic [2:0][COORD_BITS-1:0]    pb,
  output logic [2:0][COORD_BITS-1:0]    pt
);
  import tpc_pkg::*;

  localparam int DW = 2 * COORD_BITS + 3;

  logic [DW:0]           rem, rem_next;
  logic [DW-1:0]         den;
  logic [RATIO_BITS-1:0] q, q_next;
  logic [DW-1:0]         abs_a, abs_b;

  assign abs_a = sa[DW-1] ? DW'(-sa) : DW'(sa);
  assign abs_b = sb[DW-1] ? DW'(-sb) : DW'(sb);

  always_comb begin
    rem_next = rem;
    q_next = q;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      rem_next = rem_next << 1;
      q_next = {q_next[RATIO_BITS-2:0], 1'b0};
      if (rem_next >= {1'b0, den}) begin
        rem_next = rem_next - {1'b0, den};
        q_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, abs_a};
      den <= abs_a + abs_b;
      q <= '0;
    end else if (step) begin
      rem <= rem_next;
      q <= q_next;
    end
  end

  // a + floor(r * (b - a) / 2^32)
  logic signed [COORD_BITS:0]            diff [3];
  logic signed [RATIO_BITS:0]            rs;
  logic signed [COORD_BITS+RATIO_BITS+1:0] prod [3];

  assign rs = $signed({1'b0, q});

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      diff[j] = $signed({pb[j][COORD_BITS-1], pb[j]})
              - $signed({pa[j][COORD_BITS-1], pa[j]});
      prod[j] = diff[j] * rs;
      pt[j] = pa[j] + prod[j][RATIO_BITS+COORD_BITS-1:RATIO_BITS];
    end
  end

endmodule

@@ rtl/core/tpc_emit.sv @@
module tpc_emit #(
  parameter int COORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  tpc_pkg::kind_t                 kind_in,
  input  logic [7:0][2:0][COORD_BITS-1:0] pts_in,
  output logic                           free,
  tpc_out_if.source                      vtx_out
);
  import tpc_pkg::*;

  logic [7:0][2:0][COORD_BITS-1:0] pts;
  kind_t      kind;
  logic       busy;
  logic [3:0] n;
  logic [2:0] id;
  logic [3:0] final_n;
  logic       xfer;

  assign id = TET_LIST[kind][n[3:2]][n[1:0]];
  assign final_n = {TET_COUNT[kind], 2'b00} - 4'd1;
  assign xfer = vtx_out.valid && vtx_out.ready;
  assign free = !busy || (xfer && vtx_out.last);

  assign vtx_out.valid  = busy;
  assign vtx_out.out_x  = pts[id][0];
  assign vtx_out.out_y  = pts[id][1];
  assign vtx_out.out_z  = pts[id][2];
  assign vtx_out.corner = n[1:0];
  assign vtx_out.last   = (n == final_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      n <= '0;
    end else begin
      if (xfer) begin
        if (vtx_out.last) begin
          busy <= 1'b0;
        end else begin
          n <= n + 4'd1;
        end
      end
      if (load && kind_in != KIND_DROP) begin
        busy <= 1'b1;
        n <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pts <= pts_in;
      kind <= kind_in;
    end
  end

endmodule

@@ rtl/core/tetra_plane_clip.sv @@
// Channel   Dir  Carries                       Transfer
// tet_in    in   four vertices v0..v3 (x,y,z)  valid && ready
// vtx_out   out  vertex, corner, last          valid && ready
// apb       in   plane point, normal regs      psel && penable && pwrite
//
// Each tetrahedron passes the distance stages p1 and p2, then the ratio
// division (4 quotient bits per cycle), then emission, one vertex per
// cycle while vtx_out.ready is high. The emitter buffer and the division
// stage overlap consecutive items.
// Reset clears all valid flags and the configuration registers; a stalled
// vtx_out holds the current vertex and backs up through each stage to tet_in.ready.
module tetra_plane_clip #(
  parameter int COORD_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  tpc_in_if.sink    tet_in,
  tpc_out_if.source vtx_out,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [((COORD_BITS > 32) ? 6 : 5)-1:0] paddr,
  input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COORD_BITS > 32) ? 64 : 32)-1:0] prdata,
  output logic pready
);
  import tpc_pkg::*;

  localparam int DATA_W = (COORD_BITS > 32) ? 64 : 32;
  localparam int ASH = (COORD_BITS > 32) ? 3 : 2;
  localparam int ADDR_W = ASH + 3;
  localparam int DW = 2 * COORD_BITS + 3;
  localparam int CW = $clog2(DIV_STEPS + 1);

  // configuration
  logic [2:0][COORD_BITS-1:0] plane, normal;
  logic [2:0] widx;

  assign pready = 1'b1;
  assign widx = paddr[ADDR_W-1:ASH];

  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
      normal <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (widx)
        REG_PLANE_X:  plane[0] <= pwdata[COORD_BITS-1:0];
        REG_PLANE_Y:  plane[1] <= pwdata[COORD_BITS-1:0];
        REG_PLANE_Z:  plane[2] <= pwdata[COORD_BITS-1:0];
        REG_NORMAL_X: normal[0] <= pwdata[COORD_BITS-1:0];
        REG_NORMAL_Y: normal[1] <= pwdata[COORD_BITS-1:0];
        REG_NORMAL_Z: normal[2] <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_PLANE_X:  prdata = DATA_W'(plane[0]);
      REG_PLANE_Y:  prdata = DATA_W'(plane[1]);
      REG_PLANE_Z:  prdata = DATA_W'(plane[2]);
      REG_NORMAL_X: prdata = DATA_W'(normal[0]);
      REG_NORMAL_Y: prdata = DATA_W'(normal[1]);
      REG_NORMAL_Z: prdata = DATA_W'(normal[2]);
      default:      prdata = '0;
    endcase
  end

  // pipeline control
  logic p1_v, p2_v, d_v;
  logic [CW-1:0] d_cnt;
  logic in_xfer, p2_load, d_load, d_done, d_fire, e_free;

  assign d_done  = d_v && (d_cnt == CW'(DIV_STEPS));
  assign d_fire  = d_done && e_free;
  assign d_load  = p2_v && (!d_v || d_fire);
  assign p2_load = p1_v && (!p2_v || d_load);
  assign tet_in.ready = !p1_v || p2_load;
  assign in_xfer = tet_in.valid && tet_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      d_v <= 1'b0;
      d_cnt <= '0;
    end else begin
      if (in_xfer) p1_v <= 1'b1;
      else if (p2_load) p1_v <= 1'b0;
      if (p2_load) p2_v <= 1'b1;
      else if (d_load) p2_v <= 1'b0;
      if (d_load) begin
        d_v <= 1'b1;
        d_cnt <= '0;
      end else begin
        if (d_fire) d_v <= 1'b0;
        if (d_v && !d_done) d_cnt <= d_cnt + CW'(1);
      end
    end
  end

  // distance lanes
  logic [3:0][2:0][COORD_BITS-1:0] vin, v1, v2;
  logic signed [DW-1:0] sdist [4];
  logic signed [DW-1:0] s2 [4];
  logic [3:0] mask;

  assign vin[0] = {tet_in.v0_z, tet_in.v0_y, tet_in.v0_x};
  assign vin[1] = {tet_in.v1_z, tet_in.v1_y, tet_in.v1_x};
  assign vin[2] = {tet_in.v2_z, tet_in.v2_y, tet_in.v2_x};
  assign vin[3] = {tet_in.v3_z, tet_in.v3_y, tet_in.v3_x};

  for (genvar i = 0; i < 4; i++) begin : g_dist
    tpc_dist_lane #(.COORD_BITS(COORD_BITS)) u_dist (
      .clk    (clk),
      .en     (in_xfer),
      .vert   (vin[i]),
      .plane  (plane),
      .normal (normal),
      .sdist  (sdist[i])
    );
    assign mask[i] = !s2[i][DW-1] && (s2[i] != '0);
  end

  always_ff @(posedge clk) begin
    if (in_xfer) v1 <= vin;
    if (p2_load) begin
      v2 <= v1;
      for (int i = 0; i < 4; i++) s2[i] <= sdist[i];
    end
  end

  // permutation and cut lanes
  kind_t kind2, kind_d;
  logic [3:0][2:0][COORD_BITS-1:0] lp;
  logic [3:0][2:0][COORD_BITS-1:0] cut_pt;
  logic signed [DW-1:0] ls [4];
  logic [7:0][2:0][COORD_BITS-1:0] pts;

  assign kind2 = CASE_KIND[mask];

  always_comb begin
    for (int k = 0; k < 4; k++) ls[k] = s2[CASE_PERM[mask][k]];
  end

  always_ff @(posedge clk) begin
    if (d_load) begin
      kind_d <= kind2;
      for (int k = 0; k < 4; k++) lp[k] <= v2[CASE_PERM[mask][k]];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_cut
    tpc_cut_lane #(.COORD_BITS(COORD_BITS)) u_cut (
      .clk   (clk),
      .start (d_load),
      .step  (d_v && !d_done),
      .sa    (ls[EDGE_FROM[kind2][k]]),
      .sb    (ls[EDGE_TO[kind2][k]]),
      .pa    (lp[EDGE_FROM[kind_d][k]]),
      .pb    (lp[EDGE_TO[kind_d][k]]),
      .pt    (cut_pt[k])
    );
    assign pts[k] = lp[k];
    assign pts[k+4] = cut_pt[k];
  end

  tpc_emit #(.COORD_BITS(COORD_BITS)) u_emit (
    .clk     (clk),
    .rst     (rst),
    .load    (d_fire),
    .kind_in (kind_d),
    .pts_in  (pts),
    .free    (e_free),
    .vtx_out (vtx_out)
  );

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    d_cnt <= CW'(DIV_STEPS))
    else $error("division counter overran");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    vtx_out.valid && vtx_out.ready && !vtx_out.last |=> vtx_out.valid)
    else $error("vertex run broke off before last");

  a_corner_step: assert property (@(posedge clk) disable iff (rst)
    vtx_out.valid && vtx_out.ready && !vtx_out.last |=>
      vtx_out.corner == $past(vtx_out.corner) + 2'd1)
    else $error("corner did not advance");

  a_fire_done: assert property (@(posedge clk) disable iff (rst)
    d_fire |-> d_v && (d_cnt == CW'(DIV_STEPS)))
    else $error("emitter loaded before ratios were ready");

endmodule
